>>> rtl/gauss_seidel_linear_solver_core_assert.svh
// Assertion macros used by the checker file of the solver core.
// No dependencies.
`ifndef GAUSS_SEIDEL_LINEAR_SOLVER_CORE_ASSERT_SVH
`define GAUSS_SEIDEL_LINEAR_SOLVER_CORE_ASSERT_SVH
// check an implication on every clock edge outside reset
`define GS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// check an implication in the next cycle
`define GS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`endif

>>> rtl/gs_solver_pkg.sv
// Types and constants of the Gauss-Seidel solver core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gs_solver_pkg;
	localparam int ORDER = 16;
	localparam int FRAC_BITS = 16;
	localparam int IDX_W = 4;

	localparam logic [1:0] OP_MATRIX = 2'd0;
	localparam logic [1:0] OP_RHS = 2'd1;
	localparam logic [1:0] OP_GUESS = 2'd2;
	localparam logic [1:0] OP_SOLVE = 2'd3;

	localparam logic CFG_SWEEP_LIMIT = 1'b0;
	localparam logic CFG_TOLERANCE = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] row;
		logic [3:0] column;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [3:0] index;
		logic signed [31:0] entry;
		logic last;
		logic [15:0] sweeps_done;
		logic reached_tolerance;
		logic singular;
	} out_item_t;
endpackage
`default_nettype wire

>>> rtl/gauss_seidel_linear_solver_core.sv
// Gauss-Seidel solver core: load, sweep sequencer and result output.
// Depends on gs_solver_pkg.
// Load items are accepted back to back while the core is idle. A solve first
// reads the 16 diagonal entries, each through the DCHK and DCHK_W states, then
// runs each sweep row by row through one multiplier and one shift-subtract
// divider: per row a setup state, the multiply-accumulate states, a drain
// state, the divide states and the UPD and CHG states for the change measure,
// plus an end-of-sweep state after the last row. The 16 results then leave one
// per accepted cycle. The block is not ready for input or register writes from
// the solve item until the last result is taken. The matrix sits in a single-port
// memory with registered read data; the solver reads it one entry a cycle.
`timescale 1ns / 1ps
`default_nettype none
module gauss_seidel_linear_solver_core (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_ready,
	input gs_solver_pkg::in_item_t in_data,
	output logic out_valid,
	input wire out_ready,
	output gs_solver_pkg::out_item_t out_data,
	input wire cfg_valid,
	output logic cfg_ready,
	input wire cfg_index,
	input wire [63:0] cfg_data
);
	import gs_solver_pkg::*;

	typedef enum logic [3:0] {
		IDLE, DCHK, DCHK_W, RSTART, MAC, MAC_W, DIV, UPD, CHG, SWEND, EMIT
	} state_t;

	localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ACC_MIN = -64'sh7FFF_FFFF_FFFF_FFFF;

	state_t state_q;
	logic [15:0] limit_q;
	logic [63:0] tol_q;
	logic signed [31:0] mat_mem [ORDER*ORDER];
	logic signed [31:0] rhs_mem [ORDER];
	logic signed [31:0] sol_q [ORDER];
	logic signed [31:0] rd_q;
	logic [2*IDX_W-1:0] addr;
	logic [IDX_W-1:0] i_q, j_q;
	logic [IDX_W:0] cnt_q;
	logic signed [63:0] sum_q;
	logic signed [31:0] diag_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [6:0] dstep_q;
	logic neg_q;
	logic signed [31:0] fresh_q;
	logic [63:0] chg_q;
	logic [15:0] sweeps_q;
	logic sing_q, reached_q;
	logic mac_en_q;
	logic signed [63:0] prod_q;
	logic [IDX_W-1:0] pj_q;
	logic [31:0] dabs;
	logic [64:0] trial;
	logic signed [32:0] diff;
	logic [32:0] dmag;
	logic [63:0] sq;
	logic [64:0] chg_sum;
	logic signed [64:0] acc_sum;
	logic signed [63:0] sat_sum;

	assign in_ready = (state_q == IDLE);
	assign cfg_ready = (state_q == IDLE);
	assign out_valid = (state_q == EMIT);
	always_comb begin
		out_data.index = i_q;
		out_data.entry = sol_q[i_q];
		out_data.last = (i_q == IDX_W'(ORDER-1));
		out_data.sweeps_done = sweeps_q;
		out_data.reached_tolerance = reached_q;
		out_data.singular = sing_q;
	end

	always_comb begin
		addr = {i_q, j_q};
		if (state_q == IDLE)
			addr = {in_data.row, in_data.column};
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && in_valid && in_data.operation == OP_MATRIX)
			mat_mem[addr] <= in_data.value;
		rd_q <= mat_mem[addr];
		if (state_q == IDLE && in_valid && in_data.operation == OP_RHS)
			rhs_mem[in_data.row] <= in_data.value;
	end

	always_comb begin
		dabs = diag_q[31] ? 32'(-diag_q) : 32'(diag_q);
		trial = {rem_q[63:0], quo_q[63]} - {33'd0, dabs};
		diff = 33'(fresh_q) - 33'(sol_q[i_q]);
		dmag = diff[32] ? 33'(-diff) : 33'(diff);
		sq = dmag[32] ? '1 : dmag[31:0] * dmag[31:0];
		chg_sum = {1'b0, chg_q} + {1'b0, sq};
		acc_sum = 65'(sum_q) - 65'(prod_q);
		if (acc_sum > 65'(ACC_MAX)) sat_sum = ACC_MAX;
		else if (acc_sum < 65'(ACC_MIN)) sat_sum = ACC_MIN;
		else sat_sum = acc_sum[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			limit_q <= 16'd1000;
			tol_q <= 64'd1;
			for (int k = 0; k < ORDER; k++) sol_q[k] <= '0;
			i_q <= '0;
			j_q <= '0;
			cnt_q <= '0;
			sweeps_q <= '0;
			sing_q <= 1'b0;
			reached_q <= 1'b0;
			mac_en_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == CFG_SWEEP_LIMIT) limit_q <= cfg_data[15:0];
						else tol_q <= cfg_data;
					end
					if (in_valid) begin
						if (in_data.operation == OP_GUESS)
							sol_q[in_data.row] <= in_data.value;
						if (in_data.operation == OP_SOLVE) begin
							sweeps_q <= '0;
							sing_q <= 1'b0;
							reached_q <= 1'b0;
							i_q <= '0;
							j_q <= '0;
							state_q <= DCHK;
						end
					end
				end
				DCHK: begin
					cnt_q <= {1'b0, i_q};
					i_q <= i_q + 1'b1;
					j_q <= j_q + 1'b1;
					state_q <= DCHK_W;
				end
				DCHK_W: begin
					if (rd_q == 0) sing_q <= 1'b1;
					if (cnt_q == (IDX_W+1)'(ORDER-1)) begin
						i_q <= '0;
						j_q <= '0;
						if (rd_q == 0 || sing_q || limit_q == 0) state_q <= EMIT;
						else state_q <= RSTART;
					end else state_q <= DCHK;
				end
				RSTART: begin
					sum_q <= 64'(rhs_mem[i_q]) <<< FRAC_BITS;
					prod_q <= '0;
					if (i_q == '0) chg_q <= '0;
					j_q <= '0;
					cnt_q <= '0;
					mac_en_q <= 1'b0;
					state_q <= MAC;
				end
				MAC: begin
					// address j_q issued; previous read arrives in rd_q
					if (mac_en_q) begin
						if (pj_q == i_q) diag_q <= rd_q;
						prod_q <= (pj_q == i_q) ? 64'sd0 : 64'(rd_q) * 64'(sol_q[pj_q]);
					end else prod_q <= '0;
					sum_q <= sat_sum;
					pj_q <= j_q;
					mac_en_q <= 1'b1;
					cnt_q <= cnt_q + 1'b1;
					j_q <= j_q + 1'b1;
					if (cnt_q == (IDX_W+1)'(ORDER)) state_q <= MAC_W;
				end
				MAC_W: begin
					sum_q <= sat_sum;
					prod_q <= '0;
					if (cnt_q == (IDX_W+1)'(ORDER+1)) begin
						neg_q <= sat_sum[63] ^ diag_q[31];
						quo_q <= sat_sum[63] ? 64'(-sat_sum) : sat_sum;
						rem_q <= '0;
						dstep_q <= '0;
						state_q <= DIV;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				DIV: begin
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], quo_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
					dstep_q <= dstep_q + 1'b1;
					if (dstep_q == 7'd63) state_q <= UPD;
				end
				UPD: begin
					if (neg_q) fresh_q <= (quo_q >= 64'h8000_0000) ? 32'sh8000_0000
						: 32'(-quo_q);
					else fresh_q <= (quo_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
						: quo_q[31:0];
					state_q <= CHG;
				end
				CHG: begin
					chg_q <= chg_sum[64] ? '1 : chg_sum[63:0];
					sol_q[i_q] <= fresh_q;
					i_q <= i_q + 1'b1;
					if (i_q == IDX_W'(ORDER-1)) state_q <= SWEND;
					else state_q <= RSTART;
				end
				SWEND: begin
					sweeps_q <= sweeps_q + 1'b1;
					if (chg_q < tol_q) begin
						reached_q <= 1'b1;
						state_q <= EMIT;
					end else if (sweeps_q + 1'b1 == limit_q) state_q <= EMIT;
					else state_q <= RSTART;
				end
				EMIT: begin
					if (out_ready) begin
						i_q <= i_q + 1'b1;
						if (i_q == IDX_W'(ORDER-1)) state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/gs_solver_checker.sv
// Port checker for the solver core, bound to the top level.
// Depends on gs_solver_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "gauss_seidel_linear_solver_core_assert.svh"
module gs_solver_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input gs_solver_pkg::out_item_t out_data
);
	import gs_solver_pkg::*;

	`GS_ASSERT_IMP(no_overlap, clk, arst_n, out_valid, !in_ready)
	`GS_ASSERT_NEXT(hold_out, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`GS_ASSERT_NEXT(index_step, clk, arst_n, out_valid && out_ready && !out_data.last, out_valid && out_data.index == $past(out_data.index) + 1'b1)
	`GS_ASSERT_IMP(sing_no_sweep, clk, arst_n, out_valid && out_data.singular, out_data.sweeps_done == 16'd0 && !out_data.reached_tolerance)
endmodule

bind gauss_seidel_linear_solver_core gs_solver_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
